### sv/rsi_pkg.sv
// Shared types and constants for the ray-sphere intersector.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

  localparam int FRAC = 16;
  localparam int ONE  = 1 << FRAC;

  localparam int AW  = 48;   // a = D.D
  localparam int HW  = 51;   // h = oc.D, signed
  localparam int CW  = 51;   // c = oc.oc - R*R, signed
  localparam int DW  = 102;  // discriminant
  localparam int SW  = 51;   // square root
  localparam int RW  = 53;   // square root remainder
  localparam int NW  = 53;   // root numerator, signed
  localparam int MW  = 52;   // numerator magnitude
  localparam int QW  = 32;   // root quotient bits
  localparam int DRW = 49;   // root divider remainder
  localparam int NQW = FRAC; // normal quotient bits
  localparam int NRW = 31;   // normal divider remainder

  typedef enum logic [1:0] {
    REG_CX  = 2'd0,
    REG_CY  = 2'd1,
    REG_CZ  = 2'd2,
    REG_RAD = 2'd3
  } reg_idx_t;

  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] rad;
  } sphere_t;

  typedef struct packed {
    vec_t        org;
    vec_t        dir;
    logic [31:0] tmin;
    logic [31:0] tmax;
  } ray_t;

  typedef struct packed {
    logic          miss;
    ray_t          ray;
    logic [HW-1:0] h;
    logic [AW-1:0] a;
    logic [DW-1:0] disc;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic             hit;
    logic [31:0]      t;
    vec_t             pt;
    logic [2:0][17:0] nrm;
    logic             front;
    logic [2:0][16:0] col;
  } res_t;

endpackage

`default_nettype wire

### sv/rsi_front.sv
// Front part: accepts rays, forms a, h, c and the discriminant, flags misses.
// Depends on rsi_pkg. Six register stages, all advancing on en.
`timescale 1ns / 1ps
`default_nettype none

module rsi_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  rsi_pkg::ray_t    ray_in,
  input  rsi_pkg::sphere_t sph,
  output logic             ent_valid,
  output rsi_pkg::qent_t   ent
);

  rsi_pkg::vec_t cen;
  assign cen = {sph.cz, sph.cy, sph.cx};

  logic v1, v2, v3, v4, v5;
  rsi_pkg::ray_t ray1, ray2, ray3, ray4, ray5;

  // stage 1: oc = C - O
  logic [2:0][32:0] oc1, oc_next;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oc_next[i] = 33'($signed(cen[i])) - 33'($signed(ray_in.org[i]));
    end
  end

  // stage 2: products, floored by FRAC
  logic [2:0][46:0] ta2, ta_next;
  logic [2:0][48:0] th2, th_next;
  logic [2:0][47:0] tc2, tc_next;
  logic [45:0]      rr2, rr_next;
  always_comb begin
    logic signed [63:0] pdd;
    logic signed [64:0] pod;
    logic signed [65:0] poo;
    logic        [61:0] prr;
    for (int i = 0; i < 3; i++) begin
      pdd = $signed(ray1.dir[i]) * $signed(ray1.dir[i]);
      pod = $signed(oc1[i]) * $signed(ray1.dir[i]);
      poo = $signed(oc1[i]) * $signed(oc1[i]);
      ta_next[i] = pdd[62:16];
      th_next[i] = pod[64:16];
      tc_next[i] = poo[63:16];
    end
    prr = sph.rad * sph.rad;
    rr_next = prr[61:16];
  end

  // stage 3: sums
  logic [rsi_pkg::AW-1:0] a3, a3_next;
  logic [rsi_pkg::HW-1:0] h3, h3_next;
  logic [rsi_pkg::CW-1:0] c3, c3_next;
  logic                   zero3;
  always_comb begin
    a3_next = 48'(ta2[0]) + 48'(ta2[1]) + 48'(ta2[2]);
    h3_next = 51'($signed(th2[0])) + 51'($signed(th2[1])) + 51'($signed(th2[2]));
    c3_next = 51'(tc2[0]) + 51'(tc2[1]) + 51'(tc2[2]) - 51'(rr2);
  end

  // stage 4: split magnitudes into partial products
  logic [rsi_pkg::AW-1:0] a4;
  logic [rsi_pkg::HW-1:0] h4;
  logic                   zero4, cneg4;
  logic [49:0] phh, phl, pll, phh_next, phl_next, pll_next;
  logic [48:0] p11, p10, p01, p00, p11_next, p10_next, p01_next, p00_next;
  always_comb begin
    logic [50:0] hn;
    logic [50:0] cn;
    hn = h3[50] ? -h3 : h3;
    cn = c3[50] ? -c3 : c3;
    phh_next = hn[49:25] * hn[49:25];
    phl_next = hn[49:25] * hn[24:0];
    pll_next = hn[24:0] * hn[24:0];
    p11_next = a3[47:24] * cn[49:25];
    p10_next = a3[47:24] * cn[24:0];
    p01_next = a3[23:0] * cn[49:25];
    p00_next = a3[23:0] * cn[24:0];
  end

  // stage 5: h*h and a*|c|
  logic [rsi_pkg::AW-1:0] a5;
  logic [rsi_pkg::HW-1:0] h5;
  logic                   zero5, cneg5;
  logic [rsi_pkg::DW-1:0] hh5, ac5, hh_next, ac_next;
  always_comb begin
    hh_next = ({52'b0, phh} << 50) + ({52'b0, phl} << 26) + {52'b0, pll};
    ac_next = ({53'b0, p11} << 49) + ({53'b0, p10} << 24) + ({53'b0, p01} << 25)
            + {53'b0, p00};
  end

  // stage 6: discriminant
  rsi_pkg::qent_t ent_next;
  always_comb begin
    ent_next.ray  = ray5;
    ent_next.h    = h5;
    ent_next.a    = a5;
    ent_next.disc = cneg5 ? hh5 + ac5 : hh5 - ac5;
    ent_next.miss = zero5 || (!cneg5 && (hh5 < ac5));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      ent_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      ent_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1  <= ray_in;
      oc1   <= oc_next;
      ray2  <= ray1;
      ta2   <= ta_next;
      th2   <= th_next;
      tc2   <= tc_next;
      rr2   <= rr_next;
      ray3  <= ray2;
      a3    <= a3_next;
      h3    <= h3_next;
      c3    <= c3_next;
      zero3 <= (a3_next == '0) || (sph.rad == '0);
      ray4  <= ray3;
      a4    <= a3;
      h4    <= h3;
      zero4 <= zero3;
      cneg4 <= c3[50];
      phh   <= phh_next;
      phl   <= phl_next;
      pll   <= pll_next;
      p11   <= p11_next;
      p10   <= p10_next;
      p01   <= p01_next;
      p00   <= p00_next;
      ray5  <= ray4;
      a5    <= a4;
      h5    <= h4;
      zero5 <= zero4;
      cneg5 <= cneg4;
      hh5   <= hh_next;
      ac5   <= ac_next;
      ent   <= ent_next;
    end
  end

endmodule

`default_nettype wire

### sv/rsi_queue.sv
// Short queue of classified rays between front and back parts.
// Depends on rsi_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module rsi_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rsi_pkg::qent_t  din,
  input  logic            pop,
  output rsi_pkg::qent_t  dout,
  output rsi_pkg::qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  rsi_pkg::qent_t mem [DEPTH];
  logic [PW-1:0]  wr, rd;
  logic [CNW-1:0] count;

  assign stat.full  = (count == CNW'(DEPTH));
  assign stat.empty = (count == '0);
  assign dout       = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= (wr == PW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (pop) begin
        rd <= (rd == PW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= din;
    end
  end

endmodule

`default_nettype wire

### sv/rsi_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on rsi_pkg for widths. All stages advance on en.
`timescale 1ns / 1ps
`default_nettype none

module rsi_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [rsi_pkg::DW-1:0] disc,
  output logic [rsi_pkg::SW-1:0] root
);

  localparam int SW = rsi_pkg::SW;
  localparam int RW = rsi_pkg::RW;
  localparam int DW = rsi_pkg::DW;

  logic [RW-1:0] rem [SW];
  logic [SW-1:0] rt  [SW];
  logic [DW-1:0] dq  [SW];

  for (genvar k = 0; k < SW; k++) begin : g_st
    logic [RW-1:0] rem_i, sh, trial;
    logic [SW-1:0] rt_i;
    logic [DW-1:0] d_i;
    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign rt_i  = '0;
      assign d_i   = disc;
    end else begin : g_rest
      assign rem_i = rem[k-1];
      assign rt_i  = rt[k-1];
      assign d_i   = dq[k-1];
    end
    assign sh    = {rem_i[RW-3:0], d_i[DW-1 -: 2]};
    assign trial = {rt_i, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= trial) begin
          rem[k] <= sh - trial;
          rt[k]  <= {rt_i[SW-2:0], 1'b1};
        end else begin
          rem[k] <= sh;
          rt[k]  <= {rt_i[SW-2:0], 1'b0};
        end
        dq[k] <= {d_i[DW-3:0], 2'b00};
      end
    end
  end

  assign root = rt[SW-1];

endmodule

`default_nettype wire

### sv/rsi_back.sv
// Back part: square root, root division and interval test, hit point,
// normal division, facing and shade, output register. Depends on rsi_pkg, rsi_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module rsi_back (
  input  logic             clk,
  input  logic             rst,
  input  rsi_pkg::qent_t   ent,
  input  rsi_pkg::qstat_t  qstat,
  output logic             pop,
  input  rsi_pkg::sphere_t sph,
  output logic             out_valid,
  input  logic             out_ready,
  output rsi_pkg::res_t    res
);

  localparam int SW  = rsi_pkg::SW;
  localparam int DV  = rsi_pkg::QW;
  localparam int ND  = rsi_pkg::NQW;
  localparam int AW  = rsi_pkg::AW;
  localparam int HW  = rsi_pkg::HW;
  localparam int QW  = rsi_pkg::QW;
  localparam int DRW = rsi_pkg::DRW;
  localparam int NRW = rsi_pkg::NRW;
  localparam int NQW = rsi_pkg::NQW;

  typedef struct packed {
    logic          miss;
    rsi_pkg::ray_t ray;
    logic [HW-1:0] h;
    logic [AW-1:0] a;
  } sqp_t;

  typedef struct packed {
    logic           neg;
    logic           big;
    logic [DRW-1:0] rem;
    logic [QW-1:0]  low;
    logic [QW-1:0]  q;
  } rlane_t;

  typedef struct packed {
    logic              miss;
    rsi_pkg::ray_t     ray;
    logic [AW-1:0]     a;
    rlane_t [1:0]      ln;
  } rdiv_t;

  typedef struct packed {
    logic           neg;
    logic           ge;
    logic [NRW-1:0] rem;
    logic [NQW-1:0] q;
  } nlane_t;

  typedef struct packed {
    logic          hit;
    logic [31:0]   t;
    rsi_pkg::vec_t dir;
    rsi_pkg::vec_t pt;
    nlane_t [2:0]  ln;
  } ndiv_t;

  function automatic rdiv_t rstep(rdiv_t s);
    logic [DRW-1:0] sh;
    rdiv_t o;
    o = s;
    for (int l = 0; l < 2; l++) begin
      sh = {s.ln[l].rem[DRW-2:0], s.ln[l].low[QW-1]};
      if (sh >= {1'b0, s.a}) begin
        o.ln[l].rem = sh - {1'b0, s.a};
        o.ln[l].q   = {s.ln[l].q[QW-2:0], 1'b1};
      end else begin
        o.ln[l].rem = sh;
        o.ln[l].q   = {s.ln[l].q[QW-2:0], 1'b0};
      end
      o.ln[l].low = {s.ln[l].low[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic ndiv_t nstep(ndiv_t s, logic [30:0] rad);
    logic [NRW:0] sh;
    ndiv_t o;
    o = s;
    for (int i = 0; i < 3; i++) begin
      sh = {s.ln[i].rem, 1'b0};
      if (sh >= {1'b0, rad}) begin
        sh = sh - {1'b0, rad};
        o.ln[i].q = {s.ln[i].q[NQW-2:0], 1'b1};
      end else begin
        o.ln[i].q = {s.ln[i].q[NQW-2:0], 1'b0};
      end
      o.ln[i].rem = sh[NRW-1:0];
    end
    return o;
  endfunction

  logic en;
  assign en  = !out_valid || out_ready;
  assign pop = en && !qstat.empty;

  rsi_pkg::vec_t cen;
  assign cen = {sph.cz, sph.cy, sph.cx};

  // square root
  logic [SW-1:0] sqv;
  sqp_t          sqp [SW];
  logic [SW-1:0] root;

  rsi_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .disc (ent.disc),
    .root (root)
  );

  // numerators of both roots
  logic  nmv;
  rdiv_t nmp, nm_next;
  always_comb begin
    logic [rsi_pkg::NW-1:0] num;
    logic [rsi_pkg::NW-1:0] mg;
    nm_next.miss = sqp[SW-1].miss;
    nm_next.ray  = sqp[SW-1].ray;
    nm_next.a    = sqp[SW-1].a;
    for (int l = 0; l < 2; l++) begin
      if (l == 0) begin
        num = 53'($signed(sqp[SW-1].h)) - 53'(root);
      end else begin
        num = 53'($signed(sqp[SW-1].h)) + 53'(root);
      end
      mg = num[52] ? -num : num;
      nm_next.ln[l].neg = num[52];
      nm_next.ln[l].big = {12'b0, mg[51:0]} >= {sqp[SW-1].a, 16'b0};
      nm_next.ln[l].rem = {13'b0, mg[51:16]};
      nm_next.ln[l].low = {mg[15:0], 16'b0};
      nm_next.ln[l].q   = '0;
    end
  end

  // root division
  logic [DV-1:0] dvv;
  rdiv_t         dvp [DV];

  // interval test, near root first
  logic          slv, slhit;
  logic [31:0]   slt;
  rsi_pkg::ray_t slray;
  logic          sl_hit_next;
  logic [31:0]   sl_t_next;
  always_comb begin
    logic [33:0] tl [2];
    logic        inr [2];
    for (int l = 0; l < 2; l++) begin
      tl[l]  = dvp[DV-1].ln[l].neg ? -{2'b0, dvp[DV-1].ln[l].q} : {2'b0, dvp[DV-1].ln[l].q};
      inr[l] = !dvp[DV-1].ln[l].big
            && ($signed(tl[l]) >= 34'($signed(dvp[DV-1].ray.tmin)))
            && ($signed(tl[l]) <= 34'($signed(dvp[DV-1].ray.tmax)));
    end
    sl_hit_next = !dvp[DV-1].miss && (inr[0] || inr[1]);
    sl_t_next   = inr[0] ? tl[0][31:0] : tl[1][31:0];
  end

  // t * D
  logic             prv, prhit;
  logic [31:0]      prt;
  rsi_pkg::ray_t    prray;
  logic [2:0][63:0] prod, prod_next;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_next[i] = $signed(slt) * $signed(slray.dir[i]);
    end
  end

  // hit point and offset from center
  logic  ppv;
  ndiv_t ppp, pp_next;
  always_comb begin
    logic signed [48:0] s;
    logic        [32:0] d;
    logic        [32:0] md;
    pp_next.hit = prhit;
    pp_next.t   = prt;
    pp_next.dir = prray.dir;
    for (int i = 0; i < 3; i++) begin
      s = 49'($signed(prray.org[i])) + 49'($signed(prod[i][63:16]));
      priority if (s > 49'sd2147483647) begin
        pp_next.pt[i] = 32'h7fff_ffff;
      end else if (s < -49'sd2147483648) begin
        pp_next.pt[i] = 32'h8000_0000;
      end else begin
        pp_next.pt[i] = s[31:0];
      end
      d  = 33'($signed(pp_next.pt[i])) - 33'($signed(cen[i]));
      md = d[32] ? -d : d;
      pp_next.ln[i].neg = d[32];
      pp_next.ln[i].ge  = md >= {2'b0, sph.rad};
      pp_next.ln[i].rem = md[NRW-1:0];
      pp_next.ln[i].q   = '0;
    end
  end

  // normal division
  logic [ND-1:0] ndv;
  ndiv_t         ndp [ND];

  // outward normal and its dot with D
  logic             dtv, dthit;
  logic [31:0]      dtt;
  rsi_pkg::vec_t    dtpt;
  logic [2:0][17:0] dtn, dtn_next;
  logic [2:0][49:0] dtp, dtp_next;
  always_comb begin
    logic [16:0] q17;
    for (int i = 0; i < 3; i++) begin
      q17 = ndp[ND-1].ln[i].ge ? 17'(rsi_pkg::ONE) : {1'b0, ndp[ND-1].ln[i].q};
      dtn_next[i] = ndp[ND-1].ln[i].neg ? -{1'b0, q17} : {1'b0, q17};
      dtp_next[i] = $signed(ndp[ND-1].dir[i]) * $signed(dtn_next[i]);
    end
  end

  // facing, shade
  rsi_pkg::res_t res_next;
  always_comb begin
    logic signed [51:0] dot;
    logic        [17:0] n;
    logic        [18:0] cs;
    dot = 52'($signed(dtp[0])) + 52'($signed(dtp[1])) + 52'($signed(dtp[2]));
    res_next       = '0;
    res_next.hit   = 1'b1;
    res_next.t     = dtt;
    res_next.pt    = dtpt;
    res_next.front = dot[51];
    for (int i = 0; i < 3; i++) begin
      n  = dot[51] ? dtn[i] : -dtn[i];
      cs = 19'($signed(n)) + 19'(rsi_pkg::ONE);
      res_next.nrm[i] = n;
      res_next.col[i] = cs[17:1];
    end
    if (!dthit) begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv       <= '0;
      nmv       <= 1'b0;
      dvv       <= '0;
      slv       <= 1'b0;
      prv       <= 1'b0;
      ppv       <= 1'b0;
      ndv       <= '0;
      dtv       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sqv       <= {sqv[SW-2:0], pop};
      nmv       <= sqv[SW-1];
      dvv       <= {dvv[DV-2:0], nmv};
      slv       <= dvv[DV-1];
      prv       <= slv;
      ppv       <= prv;
      ndv       <= {ndv[ND-2:0], ppv};
      dtv       <= ndv[ND-1];
      out_valid <= dtv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqp[0] <= '{miss: ent.miss, ray: ent.ray, h: ent.h, a: ent.a};
      for (int k = 1; k < SW; k++) begin
        sqp[k] <= sqp[k-1];
      end
      nmp    <= nm_next;
      dvp[0] <= rstep(nmp);
      for (int k = 1; k < DV; k++) begin
        dvp[k] <= rstep(dvp[k-1]);
      end
      slhit  <= sl_hit_next;
      slt    <= sl_t_next;
      slray  <= dvp[DV-1].ray;
      prhit  <= slhit;
      prt    <= slt;
      prray  <= slray;
      prod   <= prod_next;
      ppp    <= pp_next;
      ndp[0] <= nstep(ppp, sph.rad);
      for (int k = 1; k < ND; k++) begin
        ndp[k] <= nstep(ndp[k-1], sph.rad);
      end
      dthit  <= ndp[ND-1].hit;
      dtt    <= ndp[ND-1].t;
      dtpt   <= ndp[ND-1].pt;
      dtn    <= dtn_next;
      dtp    <= dtp_next;
      res    <= res_next;
    end
  end

endmodule

`default_nettype wire

### sv/ray_sphere_intersect.sv
// Ray-sphere intersector: one ray per clock unless stalled, one configured sphere.
// Channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes center_x,
// center_y, center_z or radius; always ready. Write it only while no ray is
// in flight. in (in_valid/in_ready) takes a ray word: origin, direction and an
// inclusive t interval. out (out_valid/out_ready) gives one result word per ray,
// in order: hit, hit_t, point, facing normal, front_side and shade; a miss gives
// all zeros.
// Throughput: one ray per clock when nothing stalls. The depth of the back part
// is set by the 51-stage square root, the 32-stage root divider and the
// 16-stage normal divider.
// The front part (6 stages) feeds a short queue; it stalls only when the queue
// is full. The back part stalls as a whole while out_valid is high and out_ready
// is low, holding the result word; the queue then absorbs the front's words.
// Reset: center 0, radius 1.0, pipelines and queue empty, out_valid low.
// Depends on rsi_pkg, rsi_front, rsi_queue, rsi_sqrt, rsi_back.
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersect #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] origin_z,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic [31:0] t_min,
  input  logic [31:0] t_max,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] hit_t,
  output logic [31:0] point_x,
  output logic [31:0] point_y,
  output logic [31:0] point_z,
  output logic [17:0] normal_x,
  output logic [17:0] normal_y,
  output logic [17:0] normal_z,
  output logic        front_side,
  output logic [16:0] color_r,
  output logic [16:0] color_g,
  output logic [16:0] color_b
);

  rsi_pkg::sphere_t sph;
  rsi_pkg::ray_t    ray_in;
  rsi_pkg::qent_t   fent, qent;
  rsi_pkg::qstat_t  qstat;
  rsi_pkg::res_t    res;
  logic             fvalid, fen, push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sph.cx  <= '0;
      sph.cy  <= '0;
      sph.cz  <= '0;
      sph.rad <= 31'(rsi_pkg::ONE);
    end else if (cfg_valid) begin
      unique case (rsi_pkg::reg_idx_t'(cfg_index))
        rsi_pkg::REG_CX:  sph.cx  <= cfg_data;
        rsi_pkg::REG_CY:  sph.cy  <= cfg_data;
        rsi_pkg::REG_CZ:  sph.cz  <= cfg_data;
        rsi_pkg::REG_RAD: sph.rad <= cfg_data[30:0];
      endcase
    end
  end

  assign ray_in.org  = {origin_z, origin_y, origin_x};
  assign ray_in.dir  = {dir_z, dir_y, dir_x};
  assign ray_in.tmin = t_min;
  assign ray_in.tmax = t_max;

  assign fen      = !(fvalid && qstat.full);
  assign in_ready = fen;
  assign push     = fen && fvalid;

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (fen),
    .in_valid  (in_valid),
    .ray_in    (ray_in),
    .sph       (sph),
    .ent_valid (fvalid),
    .ent       (fent)
  );

  rsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (fent),
    .pop  (pop),
    .dout (qent),
    .stat (qstat)
  );

  rsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ent       (qent),
    .qstat     (qstat),
    .pop       (pop),
    .sph       (sph),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign hit        = res.hit;
  assign hit_t      = res.t;
  assign point_x    = res.pt[0];
  assign point_y    = res.pt[1];
  assign point_z    = res.pt[2];
  assign normal_x   = res.nrm[0];
  assign normal_y   = res.nrm[1];
  assign normal_z   = res.nrm[2];
  assign front_side = res.front;
  assign color_r    = res.col[0];
  assign color_g    = res.col[1];
  assign color_b    = res.col[2];

endmodule

`default_nettype wire

### sv/rsi_check.sv
// Port-level checks for ray_sphere_intersect, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module rsi_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [31:0] hit_t,
  input logic [31:0] point_x,
  input logic [31:0] point_y,
  input logic [31:0] point_z,
  input logic [17:0] normal_x,
  input logic [17:0] normal_y,
  input logic [17:0] normal_z,
  input logic        front_side,
  input logic [16:0] color_r,
  input logic [16:0] color_g,
  input logic [16:0] color_b
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_t)
      && $stable(point_x) && $stable(normal_x))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_t == '0 && point_x == '0 && point_y == '0
      && point_z == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0
      && !front_side && color_r == '0 && color_g == '0 && color_b == '0)
    else $error("miss word carries nonzero fields");

  a_shade: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |->
      color_r == 17'((20'($signed(normal_x)) + 20'sd65536) >> 1)
      && color_g == 17'((20'($signed(normal_y)) + 20'sd65536) >> 1)
      && color_b == 17'((20'($signed(normal_z)) + 20'sd65536) >> 1))
    else $error("shade does not follow normal");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind ray_sphere_intersect rsi_check u_rsi_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hit        (hit),
  .hit_t      (hit_t),
  .point_x    (point_x),
  .point_y    (point_y),
  .point_z    (point_z),
  .normal_x   (normal_x),
  .normal_y   (normal_y),
  .normal_z   (normal_z),
  .front_side (front_side),
  .color_r    (color_r),
  .color_g    (color_g),
  .color_b    (color_b)
);

`default_nettype wire

### tb/tb_ray_sphere_intersect.sv
// Self-checking bench for ray_sphere_intersect: rays against one configured sphere at a time.
// Scoreboard class predicts each result in wide integer math; tasks drive the ports.
// Depends on rsi_pkg and ray_sphere_intersect.
`timescale 1ns / 1ps

module tb_ray_sphere_intersect;

  typedef logic signed [255:0] wide_t;

  localparam int LIMIT = 400000;

  class ray_scoreboard;
    logic [31:0]   cx, cy, cz;
    logic [30:0]   rad;
    rsi_pkg::res_t hits_due[$];
    int            errors;

    function new();
      cx = '0; cy = '0; cz = '0;
      rad = 31'(rsi_pkg::ONE);
      errors = 0;
    endfunction

    function void set_reg(rsi_pkg::reg_idx_t idx, logic [31:0] data);
      case (idx)
        rsi_pkg::REG_CX:  cx = data;
        rsi_pkg::REG_CY:  cy = data;
        rsi_pkg::REG_CZ:  cz = data;
        rsi_pkg::REG_RAD: rad = data[30:0];
        default: ;
      endcase
    endfunction

    function wide_t sx(logic [31:0] v);
      return wide_t'($signed(v));
    endfunction

    function wide_t absw(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    function wide_t root_at(wide_t num, wide_t a);
      wide_t q;
      q = (absw(num) <<< rsi_pkg::FRAC) / a;
      if (q > (wide_t'(1) <<< 62)) q = wide_t'(1) <<< 62;
      return (num < 0) ? -q : q;
    endfunction

    function rsi_pkg::res_t predict_hit(rsi_pkg::ray_t r);
      rsi_pkg::res_t res;
      wide_t org[3], dir[3], cen[3], oc[3], pt[3], nrm[3];
      wide_t a, h, csum, c, disc, sq, cand, t, tmin, tmax, d, q, dot, n, col, rw;
      wide_t pmax, pmin;
      res = '0;
      a = 0; h = 0; csum = 0; dot = 0;
      pmax = wide_t'(64'sd2147483647);
      pmin = wide_t'(-64'sd2147483648);
      rw = wide_t'(rad);
      cen[0] = sx(cx); cen[1] = sx(cy); cen[2] = sx(cz);
      tmin = sx(r.tmin); tmax = sx(r.tmax);
      for (int i = 0; i < 3; i++) begin
        org[i] = sx(r.org[i]);
        dir[i] = sx(r.dir[i]);
        oc[i] = cen[i] - org[i];
        a += (dir[i] * dir[i]) >>> rsi_pkg::FRAC;
        h += (oc[i] * dir[i]) >>> rsi_pkg::FRAC;
        csum += (oc[i] * oc[i]) >>> rsi_pkg::FRAC;
      end
      if (a == 0 || rw == 0) return res;
      c = csum - ((rw * rw) >>> rsi_pkg::FRAC);
      disc = h * h - a * c;
      if (disc < 0) return res;
      sq = 0;
      for (int b = 63; b >= 0; b--) begin
        cand = sq | (wide_t'(1) <<< b);
        if (cand * cand <= disc) sq = cand;
      end
      t = root_at(h - sq, a);
      if (t < tmin || t > tmax) begin
        t = root_at(h + sq, a);
        if (t < tmin || t > tmax) return res;
      end
      for (int i = 0; i < 3; i++) begin
        pt[i] = org[i] + ((t * dir[i]) >>> rsi_pkg::FRAC);
        if (pt[i] > pmax) pt[i] = pmax;
        if (pt[i] < pmin) pt[i] = pmin;
        d = pt[i] - cen[i];
        q = (absw(d) <<< rsi_pkg::FRAC) / rw;
        if (q > rsi_pkg::ONE) q = rsi_pkg::ONE;
        nrm[i] = (d < 0) ? -q : q;
        dot += dir[i] * nrm[i];
      end
      res.hit = 1'b1;
      res.t = t[31:0];
      res.front = (dot < 0);
      for (int i = 0; i < 3; i++) begin
        n = res.front ? nrm[i] : -nrm[i];
        col = (n + rsi_pkg::ONE) >>> 1;
        res.pt[i] = pt[i][31:0];
        res.nrm[i] = n[17:0];
        res.col[i] = col[16:0];
      end
      return res;
    endfunction

    function void note_ray(rsi_pkg::ray_t r);
      hits_due.push_back(predict_hit(r));
    endfunction

    function void diff(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, nm, e, a);
      end
    endfunction

    function void check_result(rsi_pkg::res_t act);
      rsi_pkg::res_t e;
      if (hits_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %h", $time, act);
        return;
      end
      e = hits_due.pop_front();
      diff("hit", 32'(e.hit), 32'(act.hit));
      diff("hit_t", e.t, act.t);
      diff("front_side", 32'(e.front), 32'(act.front));
      for (int i = 0; i < 3; i++) begin
        diff($sformatf("point[%0d]", i), e.pt[i], act.pt[i]);
        diff($sformatf("normal[%0d]", i), 32'(e.nrm[i]), 32'(act.nrm[i]));
        diff($sformatf("color[%0d]", i), 32'(e.col[i]), 32'(act.col[i]));
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_ready;
  logic [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max;
  logic        out_valid, out_ready;
  logic        hit, front_side;
  logic [31:0] hit_t, point_x, point_y, point_z;
  logic [17:0] normal_x, normal_y, normal_z;
  logic [16:0] color_r, color_g, color_b;

  ray_scoreboard sb;
  int            tx_idle, rx_idle, cycles;

  ray_sphere_intersect u_top (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    rsi_pkg::res_t act;
    if (!rst && out_valid && out_ready) begin
      act.hit = hit;
      act.t = hit_t;
      act.front = front_side;
      act.pt[0] = point_x; act.pt[1] = point_y; act.pt[2] = point_z;
      act.nrm[0] = normal_x; act.nrm[1] = normal_y; act.nrm[2] = normal_z;
      act.col[0] = color_r; act.col[1] = color_g; act.col[2] = color_b;
      sb.check_result(act);
    end
  end

  function automatic logic [31:0] fx(int v);
    return 32'(v) << rsi_pkg::FRAC;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic write_reg(rsi_pkg::reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic send_ray(rsi_pkg::ray_t r);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    origin_x <= r.org[0]; origin_y <= r.org[1]; origin_z <= r.org[2];
    dir_x <= r.dir[0]; dir_y <= r.dir[1]; dir_z <= r.dir[2];
    t_min <= r.tmin; t_max <= r.tmax;
    do @(posedge clk); while (!in_ready);
    sb.note_ray(r);
    @(negedge clk);
  endtask

  function automatic rsi_pkg::ray_t make_ray(logic [31:0] ox, logic [31:0] oy,
                                             logic [31:0] oz, logic [31:0] dx,
                                             logic [31:0] dy, logic [31:0] dz,
                                             logic [31:0] lo, logic [31:0] hi);
    rsi_pkg::ray_t r;
    r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
    r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
    r.tmin = lo; r.tmax = hi;
    return r;
  endfunction

  function automatic rsi_pkg::ray_t random_ray();
    rsi_pkg::ray_t r;
    longint        cen[3], o, span, jit;
    if ($urandom_range(99) < 25) begin
      r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
      return r;
    end
    cen[0] = longint'($signed(sb.cx));
    cen[1] = longint'($signed(sb.cy));
    cen[2] = longint'($signed(sb.cz));
    span = longint'(sb.rad) * 4 + 1;
    if (span > 64'sd4000000000) span = 64'sd4000000000;
    for (int i = 0; i < 3; i++) begin
      jit = longint'($urandom) % (span / 4 + 1);
      o = cen[i] + (longint'($urandom) % span) - span / 2;
      r.org[i] = clamp32(o);
      r.dir[i] = clamp32((cen[i] - longint'($signed(r.org[i])) + jit - span / 8)
                         >>> $urandom_range(4));
    end
    case ($urandom_range(3))
      0: begin r.tmin = '0; r.tmax = 32'h7fffffff; end
      1: begin r.tmin = -fx($urandom_range(3)); r.tmax = fx($urandom_range(9)); end
      2: begin r.tmin = $urandom; r.tmax = 32'h7fffffff; end
      default: begin r.tmin = 32'h80000000; r.tmax = $urandom; end
    endcase
    return r;
  endfunction

  task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] rd);
    write_reg(rsi_pkg::REG_CX, x);
    write_reg(rsi_pkg::REG_CY, y);
    write_reg(rsi_pkg::REG_CZ, z);
    write_reg(rsi_pkg::REG_RAD, rd);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.hits_due.size() > 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    sb = new();
    sent = 0;
    tx_idle = 32; rx_idle = 54;
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    origin_x = '0; origin_y = '0; origin_z = '0;
    dir_x = '0; dir_y = '0; dir_z = '0; t_min = '0; t_max = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_ray(make_ray(0, 0, -fx(5), 0, 0, fx(1), 0, fx(100)));
    send_ray(make_ray(0, 0, 0, fx(1), 0, 0, 0, fx(100)));
    send_ray(make_ray(0, 0, 0, fx(-1), fx(-1), fx(-1), -fx(100), fx(100)));
    send_ray(make_ray(fx(3), fx(3), fx(3), 0, 0, 0, 0, fx(100)));
    send_ray(make_ray(0, fx(5), -fx(5), 0, 0, fx(1), 0, fx(100)));
    send_ray(make_ray(0, 0, -fx(5), 0, 0, fx(1), fx(10), fx(2)));
    send_ray(make_ray(0, 0, -fx(5), 0, 0, fx(1), fx(4), fx(4)));
    send_ray(make_ray(0, 0, -fx(5), 0, 0, fx(1), fx(6), fx(6)));
    send_ray(make_ray(fx(1), 0, -fx(5), 0, 0, fx(1), 0, fx(100)));
    send_ray(make_ray(0, 0, fx(5), 0, 0, -fx(1), -fx(100), fx(100)));
    send_ray(make_ray(0, 0, fx(5), 0, 0, fx(1), 0, fx(100)));
    send_ray(make_ray(0, 0, -fx(5), 0, 0, 1, 0, 32'h7fffffff));
    send_ray(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    send_ray(make_ray(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000,
                      32'h7fffffff));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0));
    send_ray(make_ray(-fx(2), fx(1), -fx(7), fx(1), 0, fx(3), 32'h80000000, 32'h7fffffff));

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: ;
        2: set_sphere(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        3: set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'd1);
        4: set_sphere(0, 0, 0, 0);
        default: set_sphere(fx($urandom_range(64)) - fx(32), $urandom & 32'h00ffffff,
                            $urandom | 32'hff000000, $urandom_range(1 << 20, 1 << 14));
      endcase
      for (int k = 0; k < ((p == 4) ? 20 : 90); k++) begin
        if (sent < 220) begin tx_idle = 32; rx_idle = 54; end
        else if (sent < 440) begin tx_idle = 54; rx_idle = 32; end
        else begin tx_idle = 0; rx_idle = 0; end
        send_ray(random_ray());
        sent++;
      end
    end

    drain();
    repeat (150) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
